// File: src/cwsc_pkg.sv
// ----------------------------------------------------------------------------
// cwsc_pkg
// Shared types and codes of the contact warm-start cache.
// ----------------------------------------------------------------------------
package cwsc_pkg;

    // input mode codes
    localparam logic [1:0] MODE_MERGE = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_MERGE = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] feature_key;
        logic [1:0]  slot;
        logic [31:0] normal_impulse;
        logic [31:0] tangent_impulse;
        logic [31:0] bitangent_impulse;
        logic        last;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  batch_index;
        logic        is_new;
        logic [1:0]  new_index;
        logic [31:0] normal_out;
        logic [31:0] tangent_out;
        logic [31:0] bitangent_out;
        logic        overflow;
        logic        batch_done;
    } out_word_t;

    // decoded command as it sits in the queue
    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic [1:0]  slot;
        logic [31:0] normal;
        logic [31:0] tangent;
        logic [31:0] bitangent;
        logic        last;
    } cmd_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_status_t;

endpackage

// File: src/cwsc_in_if.sv
// ----------------------------------------------------------------------------
// cwsc_in_if
// Input channel of the contact warm-start cache: valid, ready and one word.
// ----------------------------------------------------------------------------
interface cwsc_in_if import cwsc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/cwsc_out_if.sv
// ----------------------------------------------------------------------------
// cwsc_out_if
// Result channel of the contact warm-start cache: valid, ready and one word.
// ----------------------------------------------------------------------------
interface cwsc_out_if import cwsc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/cwsc_front.sv
// ----------------------------------------------------------------------------
// cwsc_front
// Accepts input words, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module cwsc_front import cwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cwsc_in_if.sink    req,
    output q_status_t  head,
    input  logic       pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            q_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    cmd_t dec_cmd;
    logic dec_keep;
    logic push;
    logic do_pop;

    always_comb
    begin
        dec_cmd.key       = req.data.feature_key;
        dec_cmd.slot      = req.data.slot;
        dec_cmd.normal    = req.data.normal_impulse;
        dec_cmd.tangent   = req.data.tangent_impulse;
        dec_cmd.bitangent = req.data.bitangent_impulse;
        dec_cmd.last      = req.data.last;
        dec_keep          = 1'b1;
        unique case (req.data.mode)
            MODE_MERGE: dec_cmd.op = OP_MERGE;
            MODE_WRITE: dec_cmd.op = OP_WRITE;
            MODE_CLEAR: dec_cmd.op = OP_CLEAR;
            default:
            begin
                // unused mode: accepted and dropped here
                dec_cmd.op = OP_MERGE;
                dec_keep   = 1'b0;
            end
        endcase
    end

    assign req.ready = (count_reg != CW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready && dec_keep;
    assign do_pop    = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

// File: src/cwsc_back.sv
// ----------------------------------------------------------------------------
// cwsc_back
// Executes queued commands against the contact table and registers results.
// ----------------------------------------------------------------------------
module cwsc_back import cwsc_pkg::*;
#(
    parameter int MAX_CONTACTS = 4,
    parameter int KEY_BITS     = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  head,
    output logic       pop,
    cwsc_out_if.source rsp
);

    localparam int IW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CW = $clog2(MAX_CONTACTS + 1);
    localparam int SW = CW + 2;

    logic [KEY_BITS-1:0] stored_keys_reg  [MAX_CONTACTS];
    logic [KEY_BITS-1:0] stored_keys_next [MAX_CONTACTS];
    logic [31:0]         stored_normal_reg     [MAX_CONTACTS];
    logic [31:0]         stored_normal_next    [MAX_CONTACTS];
    logic [31:0]         stored_tangent_reg    [MAX_CONTACTS];
    logic [31:0]         stored_tangent_next   [MAX_CONTACTS];
    logic [31:0]         stored_bitangent_reg  [MAX_CONTACTS];
    logic [31:0]         stored_bitangent_next [MAX_CONTACTS];

    logic [KEY_BITS-1:0] staging_keys_reg  [MAX_CONTACTS];
    logic [KEY_BITS-1:0] staging_keys_next [MAX_CONTACTS];
    logic [31:0]         staging_normal_reg     [MAX_CONTACTS];
    logic [31:0]         staging_normal_next    [MAX_CONTACTS];
    logic [31:0]         staging_tangent_reg    [MAX_CONTACTS];
    logic [31:0]         staging_tangent_next   [MAX_CONTACTS];
    logic [31:0]         staging_bitangent_reg  [MAX_CONTACTS];
    logic [31:0]         staging_bitangent_next [MAX_CONTACTS];

    logic [CW-1:0] stored_count_reg, stored_count_next;
    logic [CW-1:0] batch_pos_reg, batch_pos_next;
    logic [CW-1:0] new_count_reg, new_count_next;

    out_word_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic [KEY_BITS-1:0]     key_m;
    logic [MAX_CONTACTS-1:0] hit;
    logic                    found;
    logic [IW-1:0]           hit_idx;
    logic                    full;
    logic                    is_merge;
    logic                    is_write;
    logic                    is_clear;
    logic [SW-1:0]           slot_ext;
    logic                    wb_ok;
    logic [31:0]             pn, pt, pb;

    assign pop = head.valid && (!out_valid_reg || rsp.ready);

    assign is_merge = pop && (head.cmd.op == OP_MERGE);
    assign is_write = pop && (head.cmd.op == OP_WRITE);
    assign is_clear = pop && (head.cmd.op == OP_CLEAR);

    assign key_m    = KEY_BITS'(head.cmd.key);
    assign full     = (batch_pos_reg == CW'(MAX_CONTACTS));
    assign slot_ext = SW'(head.cmd.slot);
    assign wb_ok    = (slot_ext < SW'(stored_count_reg)) && (slot_ext < SW'(MAX_CONTACTS));

    // parallel key compare, lowest matching slot wins
    always_comb
    begin
        hit_idx = '0;
        for (int j = 0; j < MAX_CONTACTS; j++)
        begin
            hit[j] = (CW'(j) < stored_count_reg) && (stored_keys_reg[j] == key_m);
        end
        for (int j = MAX_CONTACTS - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                hit_idx = IW'(j);
            end
        end
    end

    assign found = |hit;
    assign pn    = found ? stored_normal_reg[hit_idx]    : head.cmd.normal;
    assign pt    = found ? stored_tangent_reg[hit_idx]   : head.cmd.tangent;
    assign pb    = found ? stored_bitangent_reg[hit_idx] : head.cmd.bitangent;

    always_comb
    begin
        stored_keys_next       = stored_keys_reg;
        stored_normal_next     = stored_normal_reg;
        stored_tangent_next    = stored_tangent_reg;
        stored_bitangent_next  = stored_bitangent_reg;
        staging_keys_next      = staging_keys_reg;
        staging_normal_next    = staging_normal_reg;
        staging_tangent_next   = staging_tangent_reg;
        staging_bitangent_next = staging_bitangent_reg;
        stored_count_next      = stored_count_reg;
        batch_pos_next         = batch_pos_reg;
        new_count_next         = new_count_reg;
        out_next               = out_reg;
        out_valid_next         = out_valid_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (is_write && wb_ok)
        begin
            for (int i = 0; i < MAX_CONTACTS; i++)
            begin
                if (slot_ext == SW'(i))
                begin
                    stored_normal_next[i]    = head.cmd.normal;
                    stored_tangent_next[i]   = head.cmd.tangent;
                    stored_bitangent_next[i] = head.cmd.bitangent;
                end
            end
        end

        if (is_clear)
        begin
            stored_count_next = '0;
            batch_pos_next    = '0;
            new_count_next    = '0;
        end

        if (is_merge)
        begin
            out_next       = '0;
            out_valid_next = 1'b1;
            if (full)
            begin
                out_next.overflow = 1'b1;
            end
            else
            begin
                out_next.batch_index   = 2'(batch_pos_reg);
                out_next.normal_out    = pn;
                out_next.tangent_out   = pt;
                out_next.bitangent_out = pb;
                if (!found)
                begin
                    out_next.is_new    = 1'b1;
                    out_next.new_index = 2'(new_count_reg);
                    new_count_next     = new_count_reg + 1'b1;
                end
                for (int i = 0; i < MAX_CONTACTS; i++)
                begin
                    if (batch_pos_reg == CW'(i))
                    begin
                        staging_keys_next[i]      = key_m;
                        staging_normal_next[i]    = pn;
                        staging_tangent_next[i]   = pt;
                        staging_bitangent_next[i] = pb;
                    end
                end
                batch_pos_next = batch_pos_reg + 1'b1;
            end

            // commit: entries past the new count are never read
            if (head.cmd.last)
            begin
                stored_keys_next      = staging_keys_next;
                stored_normal_next    = staging_normal_next;
                stored_tangent_next   = staging_tangent_next;
                stored_bitangent_next = staging_bitangent_next;
                stored_count_next     = batch_pos_next;
                batch_pos_next        = '0;
                new_count_next        = '0;
                out_next.batch_done   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_count_reg <= '0;
            batch_pos_reg    <= '0;
            new_count_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            stored_count_reg <= stored_count_next;
            batch_pos_reg    <= batch_pos_next;
            new_count_reg    <= new_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_keys_reg       <= stored_keys_next;
        stored_normal_reg     <= stored_normal_next;
        stored_tangent_reg    <= stored_tangent_next;
        stored_bitangent_reg  <= stored_bitangent_next;
        staging_keys_reg      <= staging_keys_next;
        staging_normal_reg    <= staging_normal_next;
        staging_tangent_reg   <= staging_tangent_next;
        staging_bitangent_reg <= staging_bitangent_next;
        out_reg               <= out_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

// File: src/contact_warm_start_cache.sv
// ----------------------------------------------------------------------------
// contact_warm_start_cache
// Warm-start cache for persistent contacts: merges a batch of new contacts
// against the stored table, takes over matched impulses and commits batches.
//
//   channel | direction | word        | notes
//   req     | in        | in_word_t   | merge, write back or clear
//   rsp     | out       | out_word_t  | one word per merge item
//
// An accepted command is registered in the two-entry queue and carried out
// once the output register is free: key compare, staging write and commit.
// Sustained rate is one item per cycle while the result side keeps up.
// A stalled result holds the output register; the queue then fills and
// req.ready drops once both entries are taken.
// Reset clears the counts, queue pointers and output valid.
// ----------------------------------------------------------------------------
module contact_warm_start_cache import cwsc_pkg::*;
#(
    parameter int MAX_CONTACTS = 4,
    parameter int KEY_BITS     = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    cwsc_in_if.sink    req,
    cwsc_out_if.source rsp
);

    q_status_t head;
    logic      pop;

    cwsc_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    cwsc_back
    #(
        .MAX_CONTACTS (MAX_CONTACTS),
        .KEY_BITS     (KEY_BITS)
    )
    u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

// File: bench/tb_contact_warm_start_cache.sv
// ----------------------------------------------------------------------------
// tb_contact_warm_start_cache
// Drives merge batches, write backs, clears and ignored commands into the
// contact warm-start cache and checks every result word in order against a
// local model of the stored and staging tables, under random idling and a
// long result-side stall.
// ----------------------------------------------------------------------------
module tb_contact_warm_start_cache import cwsc_pkg::*; ();

    localparam int         CAPACITY     = 4;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    cwsc_in_if  req ();
    cwsc_out_if rsp ();

    contact_warm_start_cache #(
        .MAX_CONTACTS(CAPACITY),
        .KEY_BITS    (32)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    // model of the committed table and of the batch being built
    logic [31:0] kept_key       [CAPACITY];
    logic [31:0] kept_normal    [CAPACITY];
    logic [31:0] kept_tangent   [CAPACITY];
    logic [31:0] kept_bitangent [CAPACITY];
    int unsigned kept_count;
    logic [31:0] staged_key       [CAPACITY];
    logic [31:0] staged_normal    [CAPACITY];
    logic [31:0] staged_tangent   [CAPACITY];
    logic [31:0] staged_bitangent [CAPACITY];
    int unsigned staged_count;
    int unsigned fresh_count;

    out_word_t   warm_start_due [$];
    out_word_t   seen;
    out_word_t   due;
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned stall_request;
    bit          sender_idles;
    bit          receiver_idles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void apply_command(input in_word_t w);
        out_word_t   r;
        int          hit;
        logic [31:0] n;
        logic [31:0] t;
        logic [31:0] b;
        r   = '0;
        hit = -1;
        n   = w.normal_impulse;
        t   = w.tangent_impulse;
        b   = w.bitangent_impulse;
        if (w.mode == MODE_WRITE)
        begin
            if (w.slot < kept_count)
            begin
                kept_normal[w.slot]    = n;
                kept_tangent[w.slot]   = t;
                kept_bitangent[w.slot] = b;
            end
        end
        else if (w.mode == MODE_CLEAR)
        begin
            kept_count   = 0;
            staged_count = 0;
            fresh_count  = 0;
        end
        else if (w.mode == MODE_MERGE)
        begin
            if (staged_count >= CAPACITY)
                r.overflow = 1'b1;
            else
            begin
                // lowest matching slot wins
                for (int j = 0; j < kept_count; j++)
                    if (hit < 0 && kept_key[j] == w.feature_key)
                        hit = j;
                r.batch_index = 2'(staged_count);
                if (hit >= 0)
                begin
                    n = kept_normal[hit];
                    t = kept_tangent[hit];
                    b = kept_bitangent[hit];
                end
                else
                begin
                    r.is_new    = 1'b1;
                    r.new_index = 2'(fresh_count);
                    fresh_count++;
                end
                r.normal_out    = n;
                r.tangent_out   = t;
                r.bitangent_out = b;
                staged_key[staged_count]       = w.feature_key;
                staged_normal[staged_count]    = n;
                staged_tangent[staged_count]   = t;
                staged_bitangent[staged_count] = b;
                staged_count++;
            end
            if (w.last)
            begin
                for (int i = 0; i < staged_count; i++)
                begin
                    kept_key[i]       = staged_key[i];
                    kept_normal[i]    = staged_normal[i];
                    kept_tangent[i]   = staged_tangent[i];
                    kept_bitangent[i] = staged_bitangent[i];
                end
                kept_count   = staged_count;
                staged_count = 0;
                fresh_count  = 0;
                r.batch_done = 1'b1;
            end
            warm_start_due.push_back(r);
        end
    endfunction

    function automatic in_word_t noise_word();
        in_word_t w;
        w.mode              = 2'($urandom);
        w.feature_key       = $urandom;
        w.slot              = 2'($urandom);
        w.normal_impulse    = $urandom;
        w.tangent_impulse   = $urandom;
        w.bitangent_impulse = $urandom;
        w.last              = 1'($urandom);
        return w;
    endfunction

    function automatic in_word_t command_word(input logic [1:0] mode);
        in_word_t w;
        w      = noise_word();
        w.mode = mode;
        return w;
    endfunction

    function automatic in_word_t merge_word(input logic [31:0] key, input logic [31:0] n,
                                            input logic [31:0] t, input logic [31:0] b,
                                            input logic last);
        in_word_t w;
        w                   = command_word(MODE_MERGE);
        w.feature_key       = key;
        w.normal_impulse    = n;
        w.tangent_impulse   = t;
        w.bitangent_impulse = b;
        w.last              = last;
        return w;
    endfunction

    function automatic in_word_t write_word(input logic [1:0] slot, input logic [31:0] n,
                                            input logic [31:0] t, input logic [31:0] b);
        in_word_t w;
        w                   = command_word(MODE_WRITE);
        w.slot              = slot;
        w.normal_impulse    = n;
        w.tangent_impulse   = t;
        w.bitangent_impulse = b;
        return w;
    endfunction

    // random contact, biased toward keys that persist from the kept table
    function automatic in_word_t contact_word(input logic last);
        in_word_t w;
        w      = command_word(MODE_MERGE);
        w.last = last;
        if (kept_count > 0 && $urandom_range(0, 9) < 6)
            w.feature_key = kept_key[$urandom_range(0, kept_count - 1)];
        else if ($urandom_range(0, 3) == 0)
            w.feature_key = 32'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic in_word_t side_word();
        return command_word(($urandom_range(0, 3) == 0) ? MODE_IGNORED : MODE_WRITE);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    task automatic send_word(input in_word_t w);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= w;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        apply_command(w);
        if (w.mode != MODE_IGNORED)
            words_sent++;
    endtask

    task automatic send_batch(input int unsigned len, input bit closed);
        for (int i = 0; i < len; i++)
        begin
            send_word(contact_word(closed && i == len - 1));
            if ($urandom_range(0, 19) == 0)
                send_word(side_word());
        end
    endtask

    task automatic wait_all_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (warm_start_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        // empty table: both contacts are new
        send_word(merge_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
        send_word(merge_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        // one contact persists, one is new
        send_word(merge_word(32'hFFFF_FFFF, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 1'b0));
        send_word(merge_word(32'h1234_5678, 32'h4000_0000, 32'hBF80_0000, 32'h0000_0001, 1'b1));
        // live slots take solver values, a slot past the table is dropped
        send_word(write_word(2'd0, 32'h3DCC_CCCD, 32'h0000_0000, 32'h8000_0000));
        send_word(write_word(2'd3, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF));
        send_word(write_word(2'd1, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000));
        send_word(command_word(MODE_IGNORED));
        send_word(merge_word(32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
        // same key twice in a batch: both new, later lookups hit the lower slot
        send_word(merge_word(32'h0000_CAFE, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 1'b0));
        send_word(merge_word(32'h0000_CAFE, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666, 1'b1));
        send_word(write_word(2'd1, 32'h7777_7777, 32'h8888_8888, 32'h9999_9999));
        send_word(merge_word(32'h0000_CAFE, 32'hAAAA_0000, 32'hBBBB_0000, 32'hCCCC_0000, 1'b1));
        // overfill: extra contacts dropped, last on a dropped one still commits
        for (int i = 1; i <= CAPACITY; i++)
            send_word(merge_word(32'(i), $urandom, $urandom, $urandom, 1'b0));
        send_word(merge_word(32'h0000_0099, $urandom, $urandom, $urandom, 1'b0));
        send_word(merge_word(32'h0000_0098, $urandom, $urandom, $urandom, 1'b1));
        // clear in the middle of a batch
        send_word(merge_word(32'h0000_0003, $urandom, $urandom, $urandom, 1'b0));
        send_word(command_word(MODE_CLEAR));
        send_word(merge_word(32'h0000_0003, $urandom, $urandom, $urandom, 1'b1));
    endtask

    task automatic test_backpressure();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        stall_request  = 80;
        for (int i = 0; i < 3; i++)
            send_batch(4, 1'b1);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int unsigned quota, input bit quiet);
        int unsigned goal;
        int unsigned pick;
        goal = words_sent + quota;
        while (words_sent < goal)
        begin
            sender_idles   = !quiet && $urandom_range(0, 3) != 0;
            receiver_idles = !quiet && $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_batch(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                       : $urandom_range(1, 4), 1'b1);
            else if (pick < 80)
            begin
                send_batch($urandom_range(1, 3), 1'b0);
                send_word(command_word(MODE_CLEAR));
            end
            else if (pick < 88)
                send_batch($urandom_range(1, 3), 1'b0);
            else if (pick < 96)
                send_word(side_word());
            else
                send_word(command_word(MODE_CLEAR));
        end
    endtask

    // result side: random stalls plus one long requested hold-off
    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_request != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall_request) @(posedge clk);
                stall_request = 0;
            end
            else if (receiver_idles && $urandom_range(0, 7) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            seen = rsp.data;
            if (warm_start_due.size() == 0)
                report_mismatch("word with nothing due", '0, seen.normal_out);
            else
            begin
                due = warm_start_due.pop_front();
                if (seen.batch_index !== due.batch_index)
                    report_mismatch("batch_index", due.batch_index, seen.batch_index);
                if (seen.is_new !== due.is_new)
                    report_mismatch("is_new", due.is_new, seen.is_new);
                if (seen.new_index !== due.new_index)
                    report_mismatch("new_index", due.new_index, seen.new_index);
                if (seen.normal_out !== due.normal_out)
                    report_mismatch("normal_out", due.normal_out, seen.normal_out);
                if (seen.tangent_out !== due.tangent_out)
                    report_mismatch("tangent_out", due.tangent_out, seen.tangent_out);
                if (seen.bitangent_out !== due.bitangent_out)
                    report_mismatch("bitangent_out", due.bitangent_out, seen.bitangent_out);
                if (seen.overflow !== due.overflow)
                    report_mismatch("overflow", due.overflow, seen.overflow);
                if (seen.batch_done !== due.batch_done)
                    report_mismatch("batch_done", due.batch_done, seen.batch_done);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.data       = '0;
        kept_count     = 0;
        staged_count   = 0;
        fresh_count    = 0;
        mismatches     = 0;
        words_sent     = 0;
        stall_request  = 0;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_backpressure();
        test_random_traffic(440, 1'b0);
        test_random_traffic(90, 1'b1);

        wait_all_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
